[rtl/core/euler_totient_trial_division_core_assert.svh]
// Assertion macros for the totient core checker.
// No dependencies; included by the checker file only.
`ifndef EULER_TOTIENT_TRIAL_DIVISION_CORE_ASSERT_SVH
`define EULER_TOTIENT_TRIAL_DIVISION_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define ETD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("totient core check failed");

// Next-cycle implication, disabled in reset
`define ETD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("totient core check failed");

`endif

[rtl/core/etd_pkg.sv]
// Shared types, microcode layout and control store for the totient core.
// No dependencies; used by etd_seq and the top level.
package etd_pkg;

    localparam int UPC_W = 5;

    // Control store addresses
    localparam logic [UPC_W-1:0] A_IDLE  = 5'd0;
    localparam logic [UPC_W-1:0] A_LOOP  = 5'd1;
    localparam logic [UPC_W-1:0] A_LWAIT = 5'd2;
    localparam logic [UPC_W-1:0] A_TEST  = 5'd3;
    localparam logic [UPC_W-1:0] A_REMT  = 5'd4;
    localparam logic [UPC_W-1:0] A_HIT   = 5'd5;
    localparam logic [UPC_W-1:0] A_AWAIT = 5'd6;
    localparam logic [UPC_W-1:0] A_ASUB  = 5'd7;
    localparam logic [UPC_W-1:0] A_SWAIT = 5'd8;
    localparam logic [UPC_W-1:0] A_STEST = 5'd9;
    localparam logic [UPC_W-1:0] A_STRIP = 5'd10;
    localparam logic [UPC_W-1:0] A_INC   = 5'd11;
    localparam logic [UPC_W-1:0] A_TAIL  = 5'd12;
    localparam logic [UPC_W-1:0] A_TGO   = 5'd13;
    localparam logic [UPC_W-1:0] A_TWAIT = 5'd14;
    localparam logic [UPC_W-1:0] A_TSUB  = 5'd15;
    localparam logic [UPC_W-1:0] A_DONE  = 5'd16;
    localparam logic [UPC_W-1:0] A_SGO   = 5'd17;

    // Divider operand selection
    typedef enum logic [1:0] {
        DS_REST_BY_D,
        DS_ANS_BY_D,
        DS_ANS_BY_REST
    } t_dsel;

    // Register write action
    typedef enum logic [2:0] {
        WR_NONE,
        WR_LOAD,
        WR_REST_Q,
        WR_ANS_SUB,
        WR_D_INC
    } t_wr;

    // Jump condition
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_IDLE,
        C_DIV_BUSY,
        C_D_GT_Q,
        C_REM_NZ,
        C_REST_LE1
    } t_cond;

    typedef struct packed {
        logic             div_go;
        t_dsel            dsel;
        t_wr              wr;
        t_cond            cond;
        logic [UPC_W-1:0] target;
        logic             done;
    } t_uword;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic start;
        logic div_busy;
        logic d_gt_q;
        logic rem_nz;
        logic rest_le1;
    } t_flags;

    function automatic t_uword mk(input logic go, input t_dsel ds, input t_wr wr,
                                  input t_cond cd, input logic [UPC_W-1:0] tg,
                                  input logic dn);
        t_uword w;
        w.div_go = go;
        w.dsel   = ds;
        w.wr     = wr;
        w.cond   = cd;
        w.target = tg;
        w.done   = dn;
        return w;
    endfunction

    // Control program: trial division with exact ans -= ans/d updates;
    // a stripped rest is written first and divided again in the following step
    function automatic t_uword ucode(input logic [UPC_W-1:0] a);
        t_uword w;
        case (a)
            A_IDLE:  w = mk(1'b0, DS_REST_BY_D,   WR_LOAD,    C_IDLE,     A_IDLE,  1'b0);
            A_LOOP:  w = mk(1'b1, DS_REST_BY_D,   WR_NONE,    C_NEXT,     A_IDLE,  1'b0);
            A_LWAIT: w = mk(1'b0, DS_REST_BY_D,   WR_NONE,    C_DIV_BUSY, A_LWAIT, 1'b0);
            A_TEST:  w = mk(1'b0, DS_REST_BY_D,   WR_NONE,    C_D_GT_Q,   A_TAIL,  1'b0);
            A_REMT:  w = mk(1'b0, DS_REST_BY_D,   WR_NONE,    C_REM_NZ,   A_INC,   1'b0);
            A_HIT:   w = mk(1'b1, DS_ANS_BY_D,    WR_REST_Q,  C_NEXT,     A_IDLE,  1'b0);
            A_AWAIT: w = mk(1'b0, DS_ANS_BY_D,    WR_NONE,    C_DIV_BUSY, A_AWAIT, 1'b0);
            A_ASUB:  w = mk(1'b1, DS_REST_BY_D,   WR_ANS_SUB, C_NEXT,     A_IDLE,  1'b0);
            A_SWAIT: w = mk(1'b0, DS_REST_BY_D,   WR_NONE,    C_DIV_BUSY, A_SWAIT, 1'b0);
            A_STEST: w = mk(1'b0, DS_REST_BY_D,   WR_NONE,    C_REM_NZ,   A_INC,   1'b0);
            A_STRIP: w = mk(1'b0, DS_REST_BY_D,   WR_REST_Q,  C_ALWAYS,   A_SGO,   1'b0);
            A_INC:   w = mk(1'b0, DS_REST_BY_D,   WR_D_INC,   C_ALWAYS,   A_LOOP,  1'b0);
            A_TAIL:  w = mk(1'b0, DS_REST_BY_D,   WR_NONE,    C_REST_LE1, A_DONE,  1'b0);
            A_TGO:   w = mk(1'b1, DS_ANS_BY_REST, WR_NONE,    C_NEXT,     A_IDLE,  1'b0);
            A_TWAIT: w = mk(1'b0, DS_ANS_BY_REST, WR_NONE,    C_DIV_BUSY, A_TWAIT, 1'b0);
            A_TSUB:  w = mk(1'b0, DS_REST_BY_D,   WR_ANS_SUB, C_NEXT,     A_IDLE,  1'b0);
            A_DONE:  w = mk(1'b0, DS_REST_BY_D,   WR_NONE,    C_ALWAYS,   A_IDLE,  1'b1);
            A_SGO:   w = mk(1'b1, DS_REST_BY_D,   WR_NONE,    C_ALWAYS,   A_SWAIT, 1'b0);
            default: w = mk(1'b0, DS_REST_BY_D,   WR_NONE,    C_ALWAYS,   A_IDLE,  1'b0);
        endcase
        return w;
    endfunction

endpackage

[rtl/core/etd_div.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
// No package dependencies; instantiated by the top level.
module etd_div #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_busy,
    output logic [WIDTH-1:0] o_quo,
    output logic [WIDTH-1:0] o_rem
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    r_cnt, n_cnt;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_dvs, n_dvs;
    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   diff;

    // Shift one dividend bit into the partial remainder and try a subtract
    always_comb begin
        rem_sh = {r_rem, r_quo[WIDTH-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_go) begin
            n_cnt = CW'(WIDTH);
            n_rem = '0;
            n_quo = i_dividend;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CW'(1);
            if (rem_sh >= {1'b0, r_dvs}) begin
                n_rem = diff[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

[rtl/core/etd_seq.sv]
// Microprogram sequencer: step counter, control store and jump logic.
// Depends on etd_pkg; instantiated by the top level.
module etd_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  etd_pkg::t_flags i_flags,
    output etd_pkg::t_uword o_uword,
    output logic            o_idle
);

    logic [etd_pkg::UPC_W-1:0] r_pc, n_pc;
    etd_pkg::t_uword           uw;
    logic                      take;

    // Fetch the current control word
    always_comb begin
        uw = etd_pkg::ucode(r_pc);
    end

    // Decode the jump condition
    always_comb begin
        unique case (uw.cond)
            etd_pkg::C_NEXT:     take = 1'b0;
            etd_pkg::C_ALWAYS:   take = 1'b1;
            etd_pkg::C_IDLE:     take = !i_flags.start;
            etd_pkg::C_DIV_BUSY: take = i_flags.div_busy;
            etd_pkg::C_D_GT_Q:   take = i_flags.d_gt_q;
            etd_pkg::C_REM_NZ:   take = i_flags.rem_nz;
            etd_pkg::C_REST_LE1: take = i_flags.rest_le1;
            default:             take = 1'b1;
        endcase
        n_pc = take ? uw.target : r_pc + etd_pkg::UPC_W'(1);
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= etd_pkg::A_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = uw;
    assign o_idle  = (r_pc == etd_pkg::A_IDLE);

endmodule

[rtl/core/euler_totient_trial_division_core.sv]
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+------------------------------------
// command   | start, busy, i_value_in        | transfer when start && !busy
// result    | o_valid, o_totient             | one-cycle strobe, never held off
//
// An item runs a microprogram around a bit-serial divider. The worst case
// is a prime near 2^WIDTH. Reset is synchronous and active low; busy falls
// as the result strobe rises, and the receiver cannot stall.
// Depends on etd_pkg, etd_seq and etd_div.
module euler_totient_trial_division_core #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_value_in,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_totient
);

    etd_pkg::t_uword uw;
    etd_pkg::t_flags flags;
    logic            idle;

    logic [WIDTH-1:0] r_rest, n_rest;
    logic [WIDTH-1:0] r_ans,  n_ans;
    logic [WIDTH-1:0] r_d,    n_d;
    logic             r_valid;
    logic [WIDTH-1:0] r_totient;

    logic [WIDTH-1:0] div_a, div_b, div_q, div_r;
    logic             div_busy;

    etd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw),
        .o_idle  (idle)
    );

    etd_div #(.WIDTH(WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (uw.div_go),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_busy     (div_busy),
        .o_quo      (div_q),
        .o_rem      (div_r)
    );

    // Select divider operands
    always_comb begin
        unique case (uw.dsel)
            etd_pkg::DS_REST_BY_D:   begin div_a = r_rest; div_b = r_d;    end
            etd_pkg::DS_ANS_BY_D:    begin div_a = r_ans;  div_b = r_d;    end
            etd_pkg::DS_ANS_BY_REST: begin div_a = r_ans;  div_b = r_rest; end
            default:                 begin div_a = r_rest; div_b = r_d;    end
        endcase
    end

    // Status back to the sequencer
    always_comb begin
        flags.start    = start;
        flags.div_busy = div_busy;
        flags.d_gt_q   = (r_d > div_q);
        flags.rem_nz   = (div_r != '0);
        flags.rest_le1 = (r_rest <= WIDTH'(1));
    end

    // Register writes; ans/d is exact, so ans*(d-1)/d is ans - ans/d
    always_comb begin
        n_rest = r_rest;
        n_ans  = r_ans;
        n_d    = r_d;
        case (uw.wr)
            etd_pkg::WR_LOAD: begin
                if (start) begin
                    n_rest = i_value_in;
                    n_ans  = i_value_in;
                    n_d    = WIDTH'(2);
                end
            end
            etd_pkg::WR_REST_Q:  n_rest = div_q;
            etd_pkg::WR_ANS_SUB: n_ans  = r_ans - div_q;
            etd_pkg::WR_D_INC:   n_d    = r_d + WIDTH'(1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rest <= n_rest;
        r_ans  <= n_ans;
        r_d    <= n_d;
        if (uw.done) begin
            r_totient <= r_ans;
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= uw.done;
        end
    end

    assign busy      = !idle;
    assign o_valid   = r_valid;
    assign o_totient = r_totient;

endmodule

[rtl/core/etd_chk.sv]
// Port-level checker for the totient core, bound to the top level.
// Depends on euler_totient_trial_division_core_assert.svh.
`include "euler_totient_trial_division_core_assert.svh"

module etd_chk #(
    parameter int WIDTH = 32
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_valid,
    input logic [WIDTH-1:0] o_totient
);

    // Accepted command raises busy
    `ETD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // Strobe lasts a single cycle
    `ETD_ASSERT_NEXT(a_strobe_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    // Result appears only as a command ends
    `ETD_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_valid, !busy && $past(busy))
    // Going idle always delivers the result
    `ETD_ASSERT_IMPL(a_fall_valid, i_clk, i_rst_n, $fell(busy), o_valid)
    // A delivered result carries known bits
    `ETD_ASSERT_IMPL(a_result_known, i_clk, i_rst_n, o_valid, !$isunknown(o_totient))

endmodule

bind euler_totient_trial_division_core etd_chk #(.WIDTH(WIDTH)) u_etd_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_totient  (o_totient)
);

[sim/euler_totient_trial_division_core_checker.sv]
// Checker for the totient core: watches the command and result channels,
// predicts phi(n) for every transfer and compares each result in order.
// Depends only on the core's port list; instantiated by the testbench top.
`timescale 1ns / 100ps

module euler_totient_trial_division_core_checker #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic [WIDTH-1:0] i_value_in,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_totient,
    output int               o_mismatches,
    output int               o_pending,
    output int               o_checked
);

    typedef struct packed {
        logic [WIDTH-1:0] arg;
        logic [WIDTH-1:0] phi;
    } t_phi_item;

    t_phi_item phi_expected[$];
    t_phi_item oldest;
    int        mismatch_count = 0;
    int        totients_checked = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = phi_expected.size();
    assign o_checked    = totients_checked;

    // Euler's totient by trial division, exact at every step
    function automatic logic [WIDTH-1:0] phi_of(input logic [WIDTH-1:0] n);
        longint unsigned ans;
        longint unsigned rest;
        longint unsigned d;
        ans  = 64'(n);
        rest = 64'(n);
        for (d = 2; d <= rest / d; d++) begin
            if (rest % d == 0) begin
                ans = (ans / d) * (d - 1);
                while (rest % d == 0)
                    rest = rest / d;
            end
        end
        // leftover above one is a single prime
        if (rest > 1)
            ans = (ans / rest) * (rest - 1);
        return ans[WIDTH-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // compare a result against the oldest outstanding prediction
            if (i_valid) begin
                if (phi_expected.size() == 0) begin
                    report_mismatch($sformatf("result with no command pending: totient=0x%0h",
                                              i_totient));
                end else begin
                    oldest = phi_expected.pop_front();
                    totients_checked++;
                    if (i_totient !== oldest.phi)
                        report_mismatch($sformatf("n=%0d: totient %0d, predicted %0d",
                                                  oldest.arg, i_totient, oldest.phi));
                end
            end
            // predict the result of each command transfer
            if (i_start && !i_busy)
                phi_expected.insert(phi_expected.size(),
                                    t_phi_item'{arg: i_value_in, phi: phi_of(i_value_in)});
        end
    end

endmodule

[sim/euler_totient_trial_division_core_test.sv]
// Testbench top for the totient core: clock, reset, directed and random commands.
// Depends on euler_totient_trial_division_core and its checker module.
`timescale 1ns / 100ps

module euler_totient_trial_division_core_test;

    localparam int WIDTH      = 32;
    localparam int IDLE_LIMIT = 100000;
    localparam int RANDOM_N   = 80;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [WIDTH-1:0] value_in;
    logic             valid;
    logic [WIDTH-1:0] totient;

    int mismatches;
    int pending;
    int checked;
    int burst_left = 0;
    int directed_sent = 0;
    int random_sent = 0;
    int idle_cycles = 0;

    // Values with cheap factorizations that hit zero, one, primes, prime
    // powers, many distinct primes and every bit set
    logic [WIDTH-1:0] directed_values[] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd36,
        32'd4093, 32'd65521, 32'd63001, 32'd65536, 32'd223092870,
        32'h0000FFFF, 32'h55555555, 32'hAAAAAAAA, 32'hC0000000,
        32'hFFFE0000, 32'hFFFF0000, 32'h80000000, 32'hFFFFFFFF
    };

    always #10 clk = ~clk;

    euler_totient_trial_division_core #(.WIDTH(WIDTH)) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_value_in (value_in),
        .o_valid    (valid),
        .o_totient  (totient)
    );

    euler_totient_trial_division_core_checker #(.WIDTH(WIDTH)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value_in   (value_in),
        .i_valid      (valid),
        .i_totient    (totient),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Product of random factors up to 251, kept within 32 bits
    function automatic logic [WIDTH-1:0] smooth_value();
        longint unsigned acc;
        longint unsigned f;
        int              count;
        acc   = 1;
        count = $urandom_range(1, 10);
        repeat (count) begin
            f = 64'($urandom_range(2, 251));
            if (acc * f <= 64'hFFFFFFFF)
                acc = acc * f;
        end
        return acc[WIDTH-1:0];
    endfunction

    // Keep the largest prime factor small so each item stays short
    function automatic logic [WIDTH-1:0] random_value();
        logic [WIDTH-1:0] k;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return WIDTH'($urandom_range(0, 4095));
        if (pick < 70) begin
            k = WIDTH'($urandom_range(1, 4095));
            return k << $urandom_range(0, 31);
        end
        if (pick < 85)
            return smooth_value();
        return WIDTH'($urandom_range(0, 65535));
    endfunction

    // Issue one command and hold it until the core takes the transfer
    task automatic send_value(input logic [WIDTH-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 3000)
                                               : $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 10);
        end
        start    <= 1'b1;
        value_in <= v;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    // Watchdog: end the run if nothing transfers for too long
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        rst_n    = 1'b0;
        start    = 1'b0;
        value_in = '0;

        // Hold reset, then release on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_values[i]) begin
            send_value(directed_values[i]);
            directed_sent++;
        end

        repeat (RANDOM_N) begin
            send_value(random_value());
            random_sent++;
        end
        start <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending != 0) @(posedge clk);
        repeat (64) @(posedge clk);

        $display("Covered %0d directed and %0d random values, %0d totients compared.",
                 directed_sent, random_sent, checked);
        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
